// File: hw/rtl/cvpq_pkg.sv
`default_nettype none
package cvpq_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_HEX   = 2'd1;
  localparam logic [1:0] MODE_NAME  = 2'd2;

  localparam int NAME_COUNT = 24;
  localparam int PAL_COUNT  = 16;
  localparam int NAME_MAX   = 12;
  localparam int DIST_W     = 18;

  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [2:0] HEX_SHORT = 3'd3;
  localparam logic [2:0] HEX_LONG  = 3'd6;
  localparam logic [2:0] HEX_SAT   = 3'd7;
  localparam logic [3:0] POS_SAT   = 4'd15;

  localparam int JOB_DEPTH = 2;

  typedef struct packed {
    logic [1:0]            mode;
    logic [2:0]            hex_count;
    logic                  hex_stopped;
    logic [23:0]           hex_digits;
    logic [NAME_COUNT-1:0] cand;
    logic [3:0]            pos;
    logic                  term;
  } parse_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [2:0]            hex_count;
    logic [23:0]           hex_digits;
    logic [NAME_COUNT-1:0] cand;
    logic [3:0]            pos;
  } job_t;

  function automatic logic [7:0] pal_chan(input logic [3:0] i, input logic [1:0] ch);
    logic [23:0] p;
    unique case (i)
      4'd0:  p = 24'h000000;
      4'd1:  p = 24'h0000AA;
      4'd2:  p = 24'h00AA00;
      4'd3:  p = 24'h00AAAA;
      4'd4:  p = 24'hAA0000;
      4'd5:  p = 24'hAA00AA;
      4'd6:  p = 24'hAA5500;
      4'd7:  p = 24'hAAAAAA;
      4'd8:  p = 24'h555555;
      4'd9:  p = 24'h5555FF;
      4'd10: p = 24'h55FF55;
      4'd11: p = 24'h55FFFF;
      4'd12: p = 24'hFF5555;
      4'd13: p = 24'hFF55FF;
      4'd14: p = 24'hFFFF55;
      default: p = 24'hFFFFFF;
    endcase
    unique case (ch)
      2'd0: return p[23:16];
      2'd1: return p[15:8];
      default: return p[7:0];
    endcase
  endfunction

  function automatic logic [8*NAME_MAX-1:0] name_text(input logic [4:0] k);
    unique case (k)
      5'd0:  return "black";
      5'd1:  return "blue";
      5'd2:  return "green";
      5'd3:  return "cyan";
      5'd4:  return "aqua";
      5'd5:  return "red";
      5'd6:  return "magenta";
      5'd7:  return "purple";
      5'd8:  return "brown";
      5'd9:  return "gray";
      5'd10: return "grey";
      5'd11: return "lightgray";
      5'd12: return "lightgrey";
      5'd13: return "darkgray";
      5'd14: return "darkgrey";
      5'd15: return "lightblue";
      5'd16: return "lightgreen";
      5'd17: return "lightcyan";
      5'd18: return "lightred";
      5'd19: return "crimson";
      5'd20: return "pink";
      5'd21: return "lightmagenta";
      5'd22: return "yellow";
      5'd23: return "white";
      default: return '0;
    endcase
  endfunction

  function automatic logic [3:0] name_len(input logic [4:0] k);
    unique case (k)
      5'd0, 5'd2, 5'd8, 5'd23:                  return 4'd5;
      5'd1, 5'd3, 5'd4, 5'd9, 5'd10, 5'd20:     return 4'd4;
      5'd5:                                     return 4'd3;
      5'd6, 5'd19:                              return 4'd7;
      5'd7, 5'd22:                              return 4'd6;
      5'd11, 5'd12, 5'd15, 5'd17:               return 4'd9;
      5'd13, 5'd14, 5'd18:                      return 4'd8;
      5'd16:                                    return 4'd10;
      5'd21:                                    return 4'd12;
      default:                                  return 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] name_index(input logic [4:0] k);
    unique case (k)
      5'd0:  return 4'd0;
      5'd1:  return 4'd1;
      5'd2:  return 4'd2;
      5'd3, 5'd4: return 4'd3;
      5'd5:  return 4'd4;
      5'd6, 5'd7: return 4'd5;
      5'd8:  return 4'd6;
      5'd9, 5'd10, 5'd11, 5'd12: return 4'd7;
      5'd13, 5'd14: return 4'd8;
      5'd15: return 4'd9;
      5'd16: return 4'd10;
      5'd17: return 4'd11;
      5'd18, 5'd19: return 4'd12;
      5'd20, 5'd21: return 4'd13;
      5'd22: return 4'd14;
      default: return 4'd15;
    endcase
  endfunction

  function automatic logic [23:0] name_rgb(input logic [4:0] k);
    unique case (k)
      5'd0:  return 24'h000000;
      5'd1:  return 24'h0000FF;
      5'd2:  return 24'h008000;
      5'd3, 5'd4: return 24'h00FFFF;
      5'd5:  return 24'hFF0000;
      5'd6:  return 24'hFF00FF;
      5'd7:  return 24'h800080;
      5'd8:  return 24'hA52A2A;
      5'd9, 5'd10: return 24'h808080;
      5'd11, 5'd12: return 24'hD3D3D3;
      5'd13, 5'd14: return 24'hA9A9A9;
      5'd15: return 24'hADD8E6;
      5'd16: return 24'h90EE90;
      5'd17: return 24'hE0FFFF;
      5'd18: return 24'hFF5555;
      5'd19: return 24'hDC143C;
      5'd20: return 24'hFFC0CB;
      5'd21: return 24'hFF77FF;
      5'd22: return 24'hFFFF00;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic [7:0] name_char(input logic [4:0] k, input logic [3:0] pos);
    logic [8*NAME_MAX-1:0] s;
    logic [3:0]            len;
    logic [3:0]            sel;
    s   = name_text(k);
    len = name_len(k);
    sel = len - pos - 4'd1;
    if (pos < len) begin
      return s[8*sel +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, 4'(c - 8'h30)};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return {1'b1, 4'(c - 8'h57)};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return {1'b1, 4'(c - 8'h37)};
    end
    return 5'd0;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cvpq_front.sv
`default_nettype none
module cvpq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    char_byte,
  input  wire logic          last_char,
  input  wire logic          job_full,
  output logic               job_push,
  output cvpq_pkg::job_t     job
);
  import cvpq_pkg::*;

  parse_t st;
  parse_t st_next;
  parse_t st_reset;
  logic   accept;
  logic [7:0] lc;
  logic [4:0] hv;

  assign in_stall = job_full;
  assign accept   = in_valid && !in_stall;
  assign job_push = accept && last_char;

  always_comb begin
    st_reset             = '0;
    st_reset.mode        = MODE_START;
    st_reset.cand        = '1;
  end

  always_comb begin
    st_next = st;
    lc      = char_byte;
    if (char_byte >= 8'h41 && char_byte <= 8'h5A) begin
      lc = char_byte + 8'd32;
    end
    hv = hex_value(char_byte);
    if (!st.term) begin
      if (char_byte == 8'h00) begin
        st_next.term = 1'b1;
      end else if (st.mode == MODE_START && char_byte == CHAR_HASH) begin
        st_next.mode = MODE_HEX;
      end else if (st.mode == MODE_HEX) begin
        if (!st.hex_stopped) begin
          if (!hv[4]) begin
            st_next.hex_stopped = 1'b1;
          end else begin
            if (st.hex_count < HEX_LONG) begin
              st_next.hex_digits = {st.hex_digits[19:0], hv[3:0]};
            end
            if (st.hex_count < HEX_SAT) begin
              st_next.hex_count = st.hex_count + 3'd1;
            end
          end
        end
      end else begin
        st_next.mode = MODE_NAME;
        for (int k = 0; k < NAME_COUNT; k++) begin
          if (name_char(5'(k), st.pos) != lc) begin
            st_next.cand[k] = 1'b0;
          end
        end
        if (st.pos < POS_SAT) begin
          st_next.pos = st.pos + 4'd1;
        end
      end
    end
  end

  always_comb begin
    job.mode       = st_next.mode;
    job.hex_count  = st_next.hex_count;
    job.hex_digits = st_next.hex_digits;
    job.cand       = st_next.cand;
    job.pos        = st_next.pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset;
    end else if (accept) begin
      if (last_char) begin
        st <= st_reset;
      end else begin
        st <= st_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cvpq_queue.sv
`default_nettype none
module cvpq_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cvpq_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                avail,
  output cvpq_pkg::job_t      head
);
  import cvpq_pkg::*;

  job_t       slots [JOB_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(JOB_DEPTH));
  assign avail = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cvpq_back.sv
`default_nettype none
module cvpq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_avail,
  input  wire cvpq_pkg::job_t job,
  output logic                job_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                color_valid,
  output logic [3:0]          palette_index,
  output logic [23:0]         exact_rgb
);
  import cvpq_pkg::*;

  logic        s1_v;
  logic        s1_ok;
  logic        s1_hex;
  logic [3:0]  s1_idx;
  logic [23:0] s1_rgb;

  logic        s2_v;
  logic        s2_ok;
  logic        s2_hex;
  logic [3:0]  s2_idx;
  logic [23:0] s2_rgb;
  logic [DIST_W-1:0] s2_dist [PAL_COUNT];

  logic en_out;
  logic en2;
  logic en1;

  logic        r_ok;
  logic        r_hex;
  logic [3:0]  r_idx;
  logic [23:0] r_rgb;

  logic [DIST_W-1:0] d_calc [PAL_COUNT];

  logic [DIST_W-1:0] t_d [4][PAL_COUNT];
  logic [3:0]        t_i [4][PAL_COUNT];
  logic [3:0]        near;

  assign en_out  = !out_valid || !out_stall;
  assign en2     = !s2_v || en_out;
  assign en1     = !s1_v || en2;
  assign job_pop = job_avail && en1;

  always_comb begin
    r_ok  = 1'b0;
    r_hex = 1'b0;
    r_idx = 4'd0;
    r_rgb = 24'd0;
    if (job.mode == MODE_HEX) begin
      r_hex = 1'b1;
      if (job.hex_count == HEX_SHORT) begin
        r_ok  = 1'b1;
        r_rgb = {job.hex_digits[11:8], job.hex_digits[11:8],
                 job.hex_digits[7:4], job.hex_digits[7:4],
                 job.hex_digits[3:0], job.hex_digits[3:0]};
      end else if (job.hex_count == HEX_LONG) begin
        r_ok  = 1'b1;
        r_rgb = job.hex_digits;
      end
    end else if (job.mode == MODE_NAME) begin
      for (int k = NAME_COUNT - 1; k >= 0; k--) begin
        if (job.cand[k] && name_len(5'(k)) == job.pos) begin
          r_ok  = 1'b1;
          r_idx = name_index(5'(k));
          r_rgb = name_rgb(5'(k));
        end
      end
    end
  end

  always_comb begin
    logic [7:0]  p;
    logic [7:0]  v;
    logic [7:0]  dd;
    logic [15:0] sq;
    for (int i = 0; i < PAL_COUNT; i++) begin
      d_calc[i] = '0;
      for (int ch = 0; ch < 3; ch++) begin
        p  = pal_chan(4'(i), 2'(ch));
        v  = s1_rgb[8*(2-ch) +: 8];
        dd = (v > p) ? v - p : p - v;
        sq = dd * dd;
        d_calc[i] = d_calc[i] + DIST_W'(sq);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PAL_COUNT; i++) begin
      t_d[0][i] = s2_dist[i];
      t_i[0][i] = 4'(i);
    end
    for (int l = 1; l < 4; l++) begin
      for (int i = 0; i < PAL_COUNT; i++) begin
        t_d[l][i] = '0;
        t_i[l][i] = '0;
      end
      for (int i = 0; i < (PAL_COUNT >> l); i++) begin
        if (t_d[l-1][2*i+1] < t_d[l-1][2*i]) begin
          t_d[l][i] = t_d[l-1][2*i+1];
          t_i[l][i] = t_i[l-1][2*i+1];
        end else begin
          t_d[l][i] = t_d[l-1][2*i];
          t_i[l][i] = t_i[l-1][2*i];
        end
      end
    end
    near = (t_d[3][1] < t_d[3][0]) ? t_i[3][1] : t_i[3][0];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ok  <= r_ok;
      s1_hex <= r_hex;
      s1_idx <= r_idx;
      s1_rgb <= r_rgb;
    end
    if (en2) begin
      s2_ok  <= s1_ok;
      s2_hex <= s1_hex;
      s2_idx <= s1_idx;
      s2_rgb <= s1_rgb;
      for (int i = 0; i < PAL_COUNT; i++) begin
        s2_dist[i] <= d_calc[i];
      end
    end
    if (en_out) begin
      color_valid   <= s2_ok;
      exact_rgb     <= s2_rgb;
      palette_index <= !s2_ok ? 4'd0 : (s2_hex ? near : s2_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_v <= job_pop;
      end
      if (en2) begin
        s2_v <= s1_v;
      end
      if (en_out) begin
        out_valid <= s2_v;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/color_value_parse_quantize.sv
// throughput: one character per cycle while the job queue is not full, and one result
// per cycle through the back pipeline while out_stall does not hold the output
// the front takes characters until the 2-entry job queue is full
// back pipeline: result select, palette distances, min-search tree into the output register
// reset (rst, synchronous): parse state to start of value, queue and pipeline emptied
`default_nettype none
module color_value_parse_quantize (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_byte,
  input  wire logic        last_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             color_valid,
  output logic [3:0]       palette_index,
  output logic [23:0]      exact_rgb
);
  import cvpq_pkg::*;

  logic job_full;
  logic job_push;
  job_t push_job;
  logic job_pop;
  logic job_avail;
  job_t head_job;

  cvpq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_byte (char_byte),
    .last_char (last_char),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (push_job)
  );

  cvpq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .avail    (job_avail),
    .head     (head_job)
  );

  cvpq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_avail     (job_avail),
    .job           (head_job),
    .job_pop       (job_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .color_valid   (color_valid),
    .palette_index (palette_index),
    .exact_rgb     (exact_rgb)
  );

endmodule
`default_nettype wire
